// ===== rtl/core/acl_pkg.sv =====
package acl_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [DATA_W-1:0] EXPIRY_RESET = 32'd3600;

  // Register index decoded from paddr[2].
  localparam logic REG_EXPIRY = 1'b0;

  // Request opcodes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/acl_ctrl.sv =====
module acl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  acl_pkg::stat_t stat,
  output acl_pkg::cmd_t  cmd
);

  acl_pkg::state_t state_r;
  acl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      acl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = acl_pkg::ST_HASH;
        end
      end
      acl_pkg::ST_HASH: begin
        if (stat.hash_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = acl_pkg::ST_SCAN;
        end
      end
      acl_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_nxt = acl_pkg::ST_COMMIT;
        end
      end
      acl_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = acl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/acl_hash.sv =====
module acl_hash #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned CNT_W         = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [acl_pkg::DATA_W-1:0] key,
  output logic                       done,
  output logic [CNT_W-1:0]           home
);

  localparam int unsigned DW      = acl_pkg::DATA_W;
  localparam int unsigned SHIFT   = $clog2(TABLE_ENTRIES);
  localparam int unsigned RECIP_W = DW + 1;
  localparam int unsigned PROD_W  = DW + RECIP_W;

  // Scaled reciprocal, rounded up: the product with any key, shifted down by
  // DW + SHIFT bits, is the exact quotient of the key by the table size.
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << (DW + SHIFT)) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);
  localparam logic [CNT_W-1:0]   MOD_LO = CNT_W'(TABLE_ENTRIES);

  logic              mul_vld_r;
  logic              sub_vld_r;
  logic              done_r;
  logic [DW-1:0]     key_r;
  logic [CNT_W-1:0]  quot_lo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  quot_mod;

  // The remainder is below the table size, so only the low bits of the key
  // and of the quotient times the table size take part in the subtraction.
  assign prod     = {{RECIP_W{1'b0}}, key_r} * {{DW{1'b0}}, RECIP};
  assign quot_mod = quot_lo_r * MOD_LO;
  assign rem_nxt  = key_r[CNT_W-1:0] - quot_mod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sub_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= start;
      sub_vld_r <= mul_vld_r;
      done_r    <= sub_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (mul_vld_r) begin
      quot_lo_r <= prod[DW+SHIFT +: CNT_W];
    end
    if (sub_vld_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

// ===== rtl/core/acl_dp.sv =====
module acl_dp #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned IDX_W         = 6,
  parameter int unsigned CNT_W         = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acl_pkg::cmd_t              cmd,
  output acl_pkg::stat_t             stat,
  input  logic                       hash_done,
  input  logic [CNT_W-1:0]           home,
  input  logic [acl_pkg::DATA_W-1:0] expiry,
  input  logic                       in_opcode,
  input  logic [acl_pkg::DATA_W-1:0] in_key_addr,
  input  logic [acl_pkg::DATA_W-1:0] in_now_seconds,
  input  logic [acl_pkg::DATA_W-1:0] in_fill_handle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [acl_pkg::SLOT_W-1:0] out_slot,
  output logic [acl_pkg::DATA_W-1:0] out_found_handle
);

  localparam int unsigned DW = acl_pkg::DATA_W;
  localparam int unsigned SW = acl_pkg::SLOT_W;

  // Request registers.
  logic          op_r;
  logic [DW-1:0] key_r;
  logic [DW-1:0] now_r;
  logic [DW-1:0] hdl_r;

  // Table storage.
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [DW-1:0]            key_mem  [TABLE_ENTRIES];
  logic [DW-1:0]            time_mem [TABLE_ENTRIES];
  logic [DW-1:0]            hdl_mem  [TABLE_ENTRIES];

  // Probe pipeline: read issue, then evaluation of the registered read data.
  logic [CNT_W-1:0] rd_cnt_r;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;
  logic             ev_vld_r;
  logic [IDX_W-1:0] ev_idx_r;
  logic             valid_q_r;
  logic [DW-1:0]    key_q_r;
  logic [DW-1:0]    time_q_r;
  logic [DW-1:0]    hdl_q_r;

  // Scan results.
  logic             match_r;
  logic             match_exp_r;
  logic [IDX_W-1:0] match_idx_r;
  logic [DW-1:0]    match_hdl_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             exp_r;
  logic [IDX_W-1:0] exp_idx_r;
  logic             old_r;
  logic [IDX_W-1:0] old_idx_r;
  logic [DW-1:0]    old_time_r;

  logic             ev_on;
  logic             is_match;
  logic             is_expired;
  logic             is_last;
  logic [DW-1:0]    age;
  logic [IDX_W-1:0] pick;
  logic             mem_we;
  logic             hit;
  logic [SW+IDX_W-1:0] slot_ext;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [SW-1:0] out_slot_r;
  logic [DW-1:0] out_hdl_r;

  assign issue   = cmd.scan_en && (rd_cnt_r < CNT_W'(TABLE_ENTRIES));
  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  assign ev_on      = cmd.scan_en && ev_vld_r;
  assign is_match   = valid_q_r && (key_q_r == key_r);
  assign age        = (now_r >= time_q_r) ? (now_r - time_q_r) : '0;
  assign is_expired = (age >= expiry);
  assign is_last    = (ev_idx_r == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      key_r <= in_key_addr;
      now_r <= in_now_seconds;
      hdl_r <= in_fill_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[pick]  <= key_r;
      time_mem[pick] <= now_r;
      hdl_mem[pick]  <= hdl_r;
    end
    if (issue) begin
      key_q_r  <= key_mem[rd_addr];
      time_q_r <= time_mem[rd_addr];
      hdl_q_r  <= hdl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r <= 1'b0;
    end else begin
      ev_vld_r <= issue && !cmd.scan_start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_cnt_r <= home;
    end else if (issue) begin
      rd_cnt_r  <= rd_cnt_r + 1'b1;
      ev_idx_r  <= rd_addr;
      valid_q_r <= valid_r[rd_addr];
    end
  end

  // Walk the probe window: first free slot, first expired and oldest live
  // slot, stopping at the first valid key match.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
      exp_r   <= 1'b0;
      old_r   <= 1'b0;
    end else if (ev_on) begin
      if (!valid_q_r) begin
        if (!free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= ev_idx_r;
        end
      end else if (is_match) begin
        match_r     <= 1'b1;
        match_exp_r <= is_expired;
        match_idx_r <= ev_idx_r;
        match_hdl_r <= hdl_q_r;
      end else begin
        if (!exp_r && is_expired) begin
          exp_r     <= 1'b1;
          exp_idx_r <= ev_idx_r;
        end
        if (!old_r || (time_q_r < old_time_r)) begin
          old_r      <= 1'b1;
          old_idx_r  <= ev_idx_r;
          old_time_r <= time_q_r;
        end
      end
    end
  end

  always_comb begin
    priority if (match_r) begin
      pick = match_idx_r;
    end else if (free_r) begin
      pick = free_idx_r;
    end else if (exp_r) begin
      pick = exp_idx_r;
    end else begin
      pick = old_idx_r;
    end
  end

  assign mem_we = cmd.commit && (op_r == acl_pkg::OP_FILL);
  assign hit    = (op_r == acl_pkg::OP_LOOKUP) && match_r && !match_exp_r;

  always_comb begin
    slot_ext = '0;
    if (hit) begin
      slot_ext = (SW+IDX_W)'(match_idx_r);
    end else if (op_r == acl_pkg::OP_FILL) begin
      slot_ext = (SW+IDX_W)'(pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r  <= hit;
      out_slot_r <= slot_ext[SW-1:0];
      out_hdl_r  <= hit ? match_hdl_r : '0;
    end
  end

  assign stat.hash_done = hash_done;
  assign stat.scan_done = ev_on && (is_match || is_last);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_found_handle = out_hdl_r;

endmodule

// ===== rtl/core/address_cache_lookup_core.sv =====
// Address cache lookup core.
// Requests arrive on the in_ channel (valid/ready): a lookup (opcode 0) asks
// for the live entry holding key_addr, a fill (opcode 1) stores key_addr,
// now_seconds and fill_handle in the table. Every request yields exactly one
// transfer on the out_ channel with hit, slot and found_handle.
// One request is in flight at a time. After the input transfer the home slot
// (key modulo TABLE_ENTRIES) is formed by a multiplication with the scaled
// reciprocal of the table size, then the probe walks from the home slot
// toward the last slot, one table read per cycle, and stops at the first
// matching valid key. The result transfer and the next input transfer can
// follow only once the probe ends, so the time per request grows with the
// number of slots probed; the sequential probe through the single table
// read port is what sets it.
// Results sit in an output register, so a stalled receiver holds the finished
// result while the core waits to write it and stops taking new requests.
// The expiry age is set through the APB port at address 0 and should be
// written only while no request is in flight.
// Reset clears all valid bits at once, empties the output register and loads
// the expiry age with 3600 seconds; no clearing pass is needed.
module address_cache_lookup_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [acl_pkg::DATA_W-1:0]     in_key_addr,
  input  logic [acl_pkg::DATA_W-1:0]     in_now_seconds,
  input  logic [acl_pkg::DATA_W-1:0]     in_fill_handle,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [acl_pkg::SLOT_W-1:0]     out_slot,
  output logic [acl_pkg::DATA_W-1:0]     out_found_handle,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [acl_pkg::DATA_W-1:0]     pwdata,
  output logic [acl_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  // Slot index width and a probe counter wide enough to hold TABLE_ENTRIES.
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  acl_pkg::cmd_t  cmd;
  acl_pkg::stat_t stat;

  logic                       hash_done;
  logic [CNT_W-1:0]           home;
  logic [acl_pkg::DATA_W-1:0] expiry_r;
  logic                       cfg_wr;
  logic                       reg_sel;

  // The single register decodes on the word address; other words read zero.
  assign reg_sel = (paddr[2] == acl_pkg::REG_EXPIRY);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? expiry_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= acl_pkg::EXPIRY_RESET;
    end else if (cfg_wr) begin
      expiry_r <= pwdata;
    end
  end

  acl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acl_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CNT_W         (CNT_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.accept),
    .key   (in_key_addr),
    .done  (hash_done),
    .home  (home)
  );

  acl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .hash_done        (hash_done),
    .home             (home),
    .expiry           (expiry_r),
    .in_opcode        (in_opcode),
    .in_key_addr      (in_key_addr),
    .in_now_seconds   (in_now_seconds),
    .in_fill_handle   (in_fill_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_found_handle (out_found_handle)
  );

endmodule

// ===== verif/tb_address_cache_lookup_core.sv =====
`timescale 1ns / 100ps

module tb_address_cache_lookup_core;

  localparam int unsigned DATA_W     = acl_pkg::DATA_W;
  localparam int unsigned SLOT_W     = acl_pkg::SLOT_W;
  localparam int unsigned CFG_ADDR_W = acl_pkg::CFG_ADDR_W;

  localparam int TABLE_ENTRIES = 64;
  localparam int POOL_SIZE = 24;
  localparam int SEGMENTS = 5;
  localparam int ITEMS_PER_SEGMENT = 400;
  // The settle time exceeds a probe of the whole table, so it covers
  // any request that might still be in flight.
  localparam int SETTLE_CYCLES = 80;
  localparam logic [CFG_ADDR_W-1:0] EXPIRY_ADDR = {acl_pkg::REG_EXPIRY, 2'b00};

  // One expected reply of the core, as it should appear on the out_ channel.
  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] handle;
  } reply_t;

  // The scoreboard keeps its own copy of the cache table and the expiry age.
  // Each accepted request is applied to that copy at once, and the reply it
  // should produce is queued until the matching result transfer shows up.
  class cache_scoreboard;
    logic [DATA_W-1:0] expiry_age;
    bit                entry_used[TABLE_ENTRIES];
    logic [DATA_W-1:0] stored_key[TABLE_ENTRIES];
    logic [DATA_W-1:0] stored_time[TABLE_ENTRIES];
    logic [DATA_W-1:0] stored_handle[TABLE_ENTRIES];
    reply_t            awaited_replies[$];
    int                mismatches;

    function new();
      expiry_age = acl_pkg::EXPIRY_RESET;
      mismatches = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_used[i] = 1'b0;
        stored_key[i] = '0;
        stored_time[i] = '0;
        stored_handle[i] = '0;
      end
    endfunction

    function void set_expiry(logic [DATA_W-1:0] age);
      expiry_age = age;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // An entry stored "in the future" has age zero and counts as stale only when the expiry age is zero.
    function bit is_stale(int idx, logic [DATA_W-1:0] now);
      logic [DATA_W-1:0] age;
      age = (now >= stored_time[idx]) ? now - stored_time[idx] : '0;
      return age >= expiry_age;
    endfunction

    function void note_request(logic op, logic [DATA_W-1:0] key,
                               logic [DATA_W-1:0] now, logic [DATA_W-1:0] handle);
      int     home;
      int     idx;
      int     pick;
      int     match_idx;
      bit     have_pick;
      bit     matched;
      bit     found_stale;
      reply_t r;
      home = int'(key % TABLE_ENTRIES);
      pick = 0;
      match_idx = 0;
      have_pick = 1'b0;
      matched = 1'b0;
      found_stale = 1'b0;
      r.hit = 1'b0;
      r.slot = '0;
      r.handle = '0;
      // Probe upward from the home slot, no wraparound; remember the first hole.
      for (idx = home; idx < TABLE_ENTRIES; idx++) begin
        if (!entry_used[idx]) begin
          if (!have_pick) begin
            pick = idx;
            have_pick = 1'b1;
          end
        end else if (stored_key[idx] == key) begin
          matched = 1'b1;
          match_idx = idx;
          break;
        end
      end
      if (op == acl_pkg::OP_LOOKUP) begin
        if (matched && !is_stale(match_idx, now)) begin
          r.hit = 1'b1;
          r.slot = match_idx[SLOT_W-1:0];
          r.handle = stored_handle[match_idx];
        end
      end else begin
        if (matched) begin
          pick = match_idx;
          have_pick = 1'b1;
        end
        if (!have_pick) begin
          for (idx = home; idx < TABLE_ENTRIES; idx++) begin
            if (is_stale(idx, now)) begin
              pick = idx;
              found_stale = 1'b1;
              break;
            end
          end
          if (!found_stale) begin
            // Evict the oldest entry; the lowest slot wins a tie.
            pick = home;
            for (idx = home + 1; idx < TABLE_ENTRIES; idx++) begin
              if (stored_time[idx] < stored_time[pick]) pick = idx;
            end
          end
        end
        entry_used[pick] = 1'b1;
        stored_key[pick] = key;
        stored_time[pick] = now;
        stored_handle[pick] = handle;
        r.slot = pick[SLOT_W-1:0];
      end
      awaited_replies.push_back(r);
    endfunction

    function void check_result(logic hit, logic [SLOT_W-1:0] slot,
                               logic [DATA_W-1:0] handle);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        flag_mismatch($sformatf("result hit=%0b slot=%0d handle=%08h with no request open",
                                hit, slot, handle));
      end else begin
        want = awaited_replies.pop_front();
        if (hit !== want.hit || slot !== want.slot || handle !== want.handle) begin
          flag_mismatch($sformatf(
            "expected hit=%0b slot=%0d handle=%08h, got hit=%0b slot=%0d handle=%08h",
            want.hit, want.slot, want.handle, hit, slot, handle));
        end
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = acl_pkg::OP_LOOKUP;
  logic [DATA_W-1:0] in_key_addr = '0;
  logic [DATA_W-1:0] in_now_seconds = '0;
  logic [DATA_W-1:0] in_fill_handle = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic [DATA_W-1:0] out_found_handle;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cache_scoreboard sb = new();

  // Idle rates in percent of cycles, changed by the main sequence per phase.
  int send_idle = 0;
  int recv_idle = 0;
  // A long receiver hold-off is requested here and counted down by the
  // receiver process itself.
  int hold_request = 0;

  logic [DATA_W-1:0] cur_time = '0;
  logic [DATA_W-1:0] key_pool[POOL_SIZE];
  logic [DATA_W-1:0] segment_expiry[SEGMENTS];

  address_cache_lookup_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_key_addr      (in_key_addr),
    .in_now_seconds   (in_now_seconds),
    .in_fill_handle   (in_fill_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_found_handle (out_found_handle),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Monitor. All stimulus changes through nonblocking assignments at the
  // rising edge, so this block sees the values that the core sampled there.
  // The request transfer is noted before the result transfer of the same
  // edge, although the two can never belong to the same request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_opcode, in_key_addr, in_now_seconds, in_fill_handle);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_hit, out_slot, out_found_handle);
      end
    end
  end

  // Receiver. It stalls at random by recv_idle, or holds off completely for
  // a requested number of cycles so that the core backs up to its input.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Hard limit on the run, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offers one request and returns at the edge where it is transferred.
  // Valid is only lowered when a gap is inserted, so a back-to-back request
  // keeps valid high without a second assignment in the same time step.
  task automatic send_request(logic op, logic [DATA_W-1:0] key,
                              logic [DATA_W-1:0] now, logic [DATA_W-1:0] handle);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_addr <= key;
    in_now_seconds <= now;
    in_fill_handle <= handle;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering requests until every expected result has arrived, then
  // lets the core settle before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the expiry age over APB, reads it back and updates the model copy.
  task automatic write_expiry(logic [DATA_W-1:0] age);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EXPIRY_ADDR;
    pwdata <= age;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== age) begin
      sb.flag_mismatch($sformatf("expiry read back %08h, expected %08h", prdata, age));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_expiry(age);
  endtask

  // Random request: mostly keys from a small pool whose home slots crowd the
  // top of the table, so fills collide, probe far and evict; a tenth are
  // arbitrary keys. Time mostly creeps forward, sometimes jumps ahead, steps
  // back (entries appear to be from the future) or lands anywhere.
  task automatic send_random_item();
    logic [DATA_W-1:0] key;
    logic              op;
    int                roll;
    roll = $urandom_range(99);
    if (roll < 10) key = $urandom;
    else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    op = 1'($urandom_range(0, 1));
    roll = $urandom_range(99);
    if (roll < 3) cur_time = $urandom;
    else if (roll < 8) cur_time = cur_time - $urandom_range(0, 400);
    else if (roll < 20) cur_time = cur_time + $urandom_range(0, 6000);
    else cur_time = cur_time + $urandom_range(0, 15);
    send_request(op, key, cur_time, $urandom);
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (i < 20) key_pool[i][SLOT_W-1:0] = SLOT_W'($urandom_range(44, 63));
    end
    // Zero expiry first, then the largest, a random short one, the reset
    // value written explicitly, and finally one second.
    segment_expiry[0] = '0;
    segment_expiry[1] = '1;
    segment_expiry[2] = $urandom_range(5, 300);
    segment_expiry[3] = acl_pkg::EXPIRY_RESET;
    segment_expiry[4] = 32'd1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 7;
    recv_idle = 84;

    // Directed part, run with the reset expiry age of 3600 seconds.
    // A lookup on the empty table misses.
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_0000, 32'd0, 32'h0);
    send_request(acl_pkg::OP_FILL, 32'h0000_0000, 32'd100, 32'hFFFF_FFFF);
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_0000, 32'd100, 32'h0);
    // Key 64 shares home slot 0 and probes on to slot 1.
    send_request(acl_pkg::OP_FILL, 32'd64, 32'd200, 32'h1234_5678);
    // Just under the expiry age it hits, at exactly the age it misses.
    send_request(acl_pkg::OP_LOOKUP, 32'd64, 32'd3799, 32'h0);
    send_request(acl_pkg::OP_LOOKUP, 32'd64, 32'd3800, 32'h0);
    // A time before the stored one counts as age zero.
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_0000, 32'd50, 32'h0);
    // A fill over a live match refreshes it in place.
    send_request(acl_pkg::OP_FILL, 32'h0000_0000, 32'd300, 32'hA5A5_A5A5);
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_0000, 32'd300, 32'h0);
    // All-ones key lands in the last slot.
    send_request(acl_pkg::OP_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(acl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    // Last slot is full and not stale, so the oldest entry is evicted.
    send_request(acl_pkg::OP_FILL, 32'h0000_007F, 32'd10, 32'h5A5A_5A5A);
    send_request(acl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd20, 32'h0);
    // Now the last slot is stale and the stale entry is taken.
    send_request(acl_pkg::OP_FILL, 32'h0000_00BF, 32'd5000, 32'h0F0F_0F0F);
    send_request(acl_pkg::OP_FILL, 32'h0000_003E, 32'd5000, 32'd1);
    // Two entries of equal age: the lower slot is evicted.
    send_request(acl_pkg::OP_FILL, 32'h0000_007E, 32'd5001, 32'd2);
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_003E, 32'd5001, 32'h0);
    send_request(acl_pkg::OP_LOOKUP, 32'h0000_007E, 32'd5001, 32'h0);
    // A fill onto a stale match reuses the matching slot.
    send_request(acl_pkg::OP_FILL, 32'd64, 32'd9000, 32'd3);
    send_request(acl_pkg::OP_LOOKUP, 32'd64, 32'd9000, 32'h0);
    send_request(acl_pkg::OP_LOOKUP, 32'h8765_4321, 32'hFFFF_FFFF, 32'h0);
    cur_time = 32'd20000;

    // Random part in segments; each begins with the core drained, so the
    // sender pauses until every result is back before the register changes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      write_expiry(segment_expiry[seg]);
      if (seg < 2) begin
        send_idle = 7;
        recv_idle = 84;
      end else if (seg < 4) begin
        send_idle = 84;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // Long receiver hold-off while requests keep coming, so the core
      // fills up and stalls its input.
      if (seg == 1) hold_request = 600;
      repeat (ITEMS_PER_SEGMENT) send_random_item();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/acl_pkg.sv
rtl/core/acl_ctrl.sv
rtl/core/acl_hash.sv
rtl/core/acl_dp.sv
rtl/core/address_cache_lookup_core.sv
verif/tb_address_cache_lookup_core.sv
